// ----- rtl/core/dzr_pkg.sv -----
`timescale 1ns / 1ps
package dzr_pkg;

  localparam int unsigned MaxBytes = 5;
  localparam logic [7:0] RunLimit = 8'hFF;
  localparam logic [7:0] RunTag = 8'h00;
  localparam logic [7:0] DiffTag = 8'h01;

  typedef struct packed {
    logic [31:0] sample;
    logic        first_of_series;
    logic        last_of_series;
    logic        wide_series;
  } samp_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       series_done;
  } code_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               count;
    logic                     last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/core/delta_zero_run_encoder.sv -----
`timescale 1ns / 1ps
// Delta encoder with zero-run compression.
// Input channel samp (samp_valid / samp_stall): one sample per transaction,
// marked first_of_series / last_of_series; wide_series is read on the first
// sample and selects a 4-byte header, else a 2-byte header.
// Output channel code (code_valid / code_stall): one byte per transaction,
// with last_of_item on the final byte of a sample and series_done on the
// final byte of a series. A sample gives 0 to 5 bytes.
// The front stage encodes a sample in the cycle it is accepted and pushes a
// byte group into a QUEUE_DEPTH-entry queue; the back stage sends one byte a
// cycle from the queue head unless stalled, through a registered output.
// Throughput: one sample per cycle into the queue while it is not full, one
// byte per cycle out while code_stall is low; the output port sets the rate.
// samp_stall rises while the queue is full; a stalled output holds its byte
// and the queue keeps filling. Reset clears the previous sample, the pending
// run and the series width, and empties the queue.
module delta_zero_run_encoder
  import dzr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  samp_valid,
  output logic  samp_stall,
  input  samp_t samp,
  output logic  code_valid,
  input  logic  code_stall,
  output code_t code
);

  logic    push;
  logic    pop;
  cmd_t    cmd;
  cmd_t    head;
  q_stat_t stat;

  dzr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .samp_valid (samp_valid),
    .samp       (samp),
    .q_full     (stat.full),
    .samp_stall (samp_stall),
    .push       (push),
    .cmd        (cmd)
  );

  dzr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  dzr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .stat       (stat),
    .pop        (pop),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code       (code)
  );

  a_done_is_final: assert property (@(posedge clk) disable iff (rst)
    code_valid && code.series_done |-> code.last_of_item)
    else $error("series_done without last_of_item");

  a_reset_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !code_valid)
    else $error("output valid right after reset");

  a_header_queued: assert property (@(posedge clk) disable iff (rst)
    samp_valid && !samp_stall && samp.first_of_series |=> !stat.empty)
    else $error("header bytes not queued");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    samp_stall |-> !stat.empty)
    else $error("input stalled with empty queue");

endmodule

// ----- rtl/core/dzr_front.sv -----
`timescale 1ns / 1ps
module dzr_front
  import dzr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  samp_valid,
  input  samp_t samp,
  input  logic  q_full,
  output logic  samp_stall,
  output logic  push,
  output cmd_t  cmd
);

  logic [31:0] previous_sample;
  logic [31:0] previous_sample_next;
  logic [7:0]  zero_run;
  logic [7:0]  zero_run_next;
  logic        wide_mode;
  logic        wide_mode_next;
  logic [31:0] cur;
  logic [31:0] diff;
  logic [7:0]  run_inc;
  logic        accept;

  assign samp_stall = q_full;
  assign accept     = samp_valid && !q_full;
  assign push       = accept && (cmd.count != 3'd0);

  always_comb begin
    cur     = wide_mode ? samp.sample : {16'h0000, samp.sample[15:0]};
    diff    = cur - previous_sample;
    if (!wide_mode) begin
      diff[31:16] = 16'h0000;
    end
    run_inc = zero_run + 8'd1;

    previous_sample_next = cur;
    zero_run_next        = zero_run;
    wide_mode_next       = wide_mode;
    cmd.bytes            = '0;
    cmd.count            = 3'd0;
    cmd.last             = samp.last_of_series;

    if (samp.first_of_series) begin
      wide_mode_next = samp.wide_series;
      zero_run_next  = 8'd0;
      if (samp.wide_series) begin
        previous_sample_next = samp.sample;
        cmd.bytes[0] = samp.sample[31:24];
        cmd.bytes[1] = samp.sample[23:16];
        cmd.bytes[2] = samp.sample[15:8];
        cmd.bytes[3] = samp.sample[7:0];
        cmd.count    = 3'd4;
      end else begin
        previous_sample_next = {16'h0000, samp.sample[15:0]};
        cmd.bytes[0] = samp.sample[15:8];
        cmd.bytes[1] = samp.sample[7:0];
        cmd.count    = 3'd2;
      end
    end else if (diff == 32'd0) begin
      if (run_inc == RunLimit || samp.last_of_series) begin
        cmd.bytes[0]  = RunTag;
        cmd.bytes[1]  = run_inc;
        cmd.count     = 3'd2;
        zero_run_next = 8'd0;
      end else begin
        zero_run_next = run_inc;
      end
    end else begin
      zero_run_next = 8'd0;
      if (zero_run != 8'd0) begin
        cmd.bytes[0] = RunTag;
        cmd.bytes[1] = zero_run;
        cmd.bytes[2] = DiffTag;
        cmd.bytes[3] = diff[15:8];
        cmd.bytes[4] = diff[7:0];
        cmd.count    = 3'd5;
      end else begin
        cmd.bytes[0] = DiffTag;
        cmd.bytes[1] = diff[15:8];
        cmd.bytes[2] = diff[7:0];
        cmd.count    = 3'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= 32'd0;
      zero_run        <= 8'd0;
      wide_mode       <= 1'b0;
    end else if (accept) begin
      previous_sample <= previous_sample_next;
      zero_run        <= zero_run_next;
      wide_mode       <= wide_mode_next;
    end
  end

endmodule

// ----- rtl/core/dzr_queue.sv -----
`timescale 1ns / 1ps
module dzr_queue
  import dzr_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  cmd_t            entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign head       = entries[rd_ptr];
  assign stat.full  = (fill == FullCnt);
  assign stat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/core/dzr_back.sv -----
`timescale 1ns / 1ps
module dzr_back
  import dzr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    head,
  input  q_stat_t stat,
  output logic    pop,
  output logic    code_valid,
  input  logic    code_stall,
  output code_t   code
);

  logic [2:0] idx;
  logic       load;
  logic       final_byte;

  assign load       = !stat.empty && (!code_valid || !code_stall);
  assign final_byte = (idx == head.count - 3'd1);
  assign pop        = load && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
      idx        <= 3'd0;
    end else begin
      if (load) begin
        code_valid <= 1'b1;
        idx        <= final_byte ? 3'd0 : idx + 3'd1;
      end else if (!code_stall) begin
        code_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code.out_byte     <= head.bytes[idx];
      code.last_of_item <= final_byte;
      code.series_done  <= final_byte && head.last;
    end
  end

endmodule
